// ----- src/text_console_terminal_assert.svh -----
// assertion macros for the checker file
`ifndef TEXT_CONSOLE_TERMINAL_ASSERT_SVH
`define TEXT_CONSOLE_TERMINAL_ASSERT_SVH

// clocked assertion, off while reset is asserted
`define TCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also checks during reset
`define TCT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/tct_pkg.sv -----
`default_nettype none
package tct_pkg;

  localparam int ROWS_DEF    = 25;
  localparam int COLUMNS_DEF = 80;

  localparam int CELL_W      = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  // fixed field widths
  localparam int ROW_FW  = 5;
  localparam int COL_FW  = 7;
  localparam int POS_FW  = 11;

  // character codes
  localparam logic [6:0] CHR_BS    = 7'd8;
  localparam logic [6:0] CHR_TAB   = 7'd9;
  localparam logic [6:0] CHR_LF    = 7'd10;
  localparam logic [6:0] CHR_FF    = 7'd12;
  localparam logic [6:0] CHR_CR    = 7'd13;
  localparam logic [6:0] CHR_SPACE = 7'd32;
  localparam logic [6:0] CHR_TILDE = 7'd126;

  // register indexes
  localparam logic [1:0] REG_BLINK = 2'd0;
  localparam logic [1:0] REG_BG    = 2'd1;
  localparam logic [1:0] REG_FG    = 2'd2;

  localparam logic       BLINK_RST = 1'b0;
  localparam logic [2:0] BG_RST    = 3'd0;
  localparam logic [3:0] FG_RST    = 4'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUT,
    OP_READ,
    OP_ZERO,
    OP_BLANK,
    OP_COPY
  } ram_op_t;

  typedef struct packed {
    logic    load_item;
    logic    exec;
    logic    sweep_clr;
    logic    sweep_inc;
    logic    load_out;
    ram_op_t op;
  } tct_cmd_t;

  typedef struct packed {
    logic is_print;
    logic is_read;
    logic need_scroll;
    logic need_clear;
    logic copy_end;
    logic sweep_last;
    logic out_block;
  } tct_sts_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic b, input logic [2:0] bg,
                                                  input logic [3:0] fg,
                                                  input logic [6:0] code);
    return {b, bg, fg, 1'b0, code};
  endfunction

endpackage
`default_nettype wire

// ----- src/tct_screen_ram.sv -----
`default_nettype none
module tct_screen_ram #(
  parameter int DEPTH = tct_pkg::ROWS_DEF * tct_pkg::COLUMNS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [tct_pkg::CELL_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [AW-1:0]             raddr,
  output logic      [tct_pkg::CELL_W-1:0] rdata_r
);

  logic [tct_pkg::CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- src/tct_ctrl.sv -----
`default_nettype none
module tct_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire tct_pkg::tct_sts_t sts,
  output tct_pkg::tct_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_CLEAR,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r;

  assign in_tready = ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.op    = tct_pkg::OP_NONE;
    case (state_r)
      ST_INIT: begin
        cmd.op = tct_pkg::OP_ZERO;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_tvalid && ready_r) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec      = 1'b1;
        cmd.sweep_clr = 1'b1;
        if (sts.is_print) begin
          cmd.op = tct_pkg::OP_PUT;
        end else if (sts.is_read) begin
          cmd.op = tct_pkg::OP_READ;
        end
        if (sts.need_scroll) begin
          state_nxt = ST_SCROLL;
        end else if (sts.need_clear) begin
          state_nxt = ST_CLEAR;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCROLL: begin
        cmd.op = tct_pkg::OP_COPY;
        if (sts.copy_end) begin
          state_nxt = ST_FILL;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      ST_FILL, ST_CLEAR: begin
        cmd.op = tct_pkg::OP_BLANK;
        if (sts.sweep_last) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      ST_DONE: begin
        if (!sts.out_block) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= (state_nxt == ST_IDLE);
    end
  end

endmodule
`default_nettype wire

// ----- src/tct_datapath.sv -----
`default_nettype none
module tct_datapath #(
  parameter int ROWS    = tct_pkg::ROWS_DEF,
  parameter int COLUMNS = tct_pkg::COLUMNS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [tct_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic                           in_tuser,
  input  wire tct_pkg::tct_cmd_t              cmd,
  output tct_pkg::tct_sts_t                   sts,
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_idx,
  input  wire logic [tct_pkg::CFG_DW-1:0]     cfg_wdata,
  output logic      [tct_pkg::CFG_DW-1:0]     cfg_rdata,
  input  wire logic                           out_tready,
  output logic                                out_tvalid,
  output logic      [tct_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int AW     = $clog2(CELLS);
  localparam int RW     = $clog2(ROWS);
  localparam int CW     = $clog2(COLUMNS);
  localparam int COPY_N = (ROWS - 1) * COLUMNS;
  localparam int PAD_W  = tct_pkg::OUT_TDATA_W - tct_pkg::ROW_FW - tct_pkg::COL_FW
                          - tct_pkg::POS_FW - tct_pkg::CELL_W;

  // item registers
  logic                       act_r;
  logic [6:0]                 chr_r;
  logic [tct_pkg::ROW_FW-1:0] rrow_r;
  logic [tct_pkg::COL_FW-1:0] rcol_r;

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [AW-1:0] sweep_r;
  logic          blink_r;
  logic [2:0]    bg_r;
  logic [3:0]    fg_r;
  logic          out_valid_r;
  logic [tct_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic          is_char, is_print, wrap, at_bottom, scroll, clear, rd_ok;
  logic [CW:0]   col_inc;
  logic [AW-1:0] cur_lin, rd_lin;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [tct_pkg::CELL_W-1:0] ram_wdata, ram_rdata;
  logic [tct_pkg::CELL_W-1:0] read_data;

  // character decode and next cursor
  assign is_char   = !act_r;
  assign is_print  = is_char && (chr_r inside {[tct_pkg::CHR_SPACE:tct_pkg::CHR_TILDE]});
  assign col_inc   = {1'b0, col_r} + (CW+1)'(1);
  assign wrap      = col_inc >= (CW+1)'(COLUMNS);
  assign at_bottom = row_r == RW'(ROWS - 1);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    scroll  = 1'b0;
    clear   = 1'b0;
    if (is_print) begin
      if (wrap) begin
        col_nxt = '0;
        if (at_bottom) begin
          scroll = 1'b1;
        end else begin
          row_nxt = row_r + RW'(1);
        end
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end else if (is_char) begin
      case (chr_r)
        tct_pkg::CHR_BS: begin
          if (col_r != '0) begin
            col_nxt = col_r - CW'(1);
          end
        end
        tct_pkg::CHR_TAB: begin
          if (col_r <= CW'(COLUMNS - 8)) begin
            col_nxt = col_r + CW'(4);
          end
        end
        tct_pkg::CHR_LF: begin
          col_nxt = '0;
          if (at_bottom) begin
            scroll = 1'b1;
          end else begin
            row_nxt = row_r + RW'(1);
          end
        end
        tct_pkg::CHR_FF: begin
          clear   = 1'b1;
          row_nxt = '0;
          col_nxt = '0;
        end
        tct_pkg::CHR_CR: begin
          col_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign rd_ok   = act_r && (32'(rrow_r) < ROWS) && (32'(rcol_r) < COLUMNS);
  assign cur_lin = AW'(32'(row_r) * COLUMNS + 32'(col_r));
  assign rd_lin  = AW'(32'(rrow_r) * COLUMNS + 32'(rcol_r));

  assign sts.is_print    = is_print;
  assign sts.is_read     = act_r;
  assign sts.need_scroll = scroll;
  assign sts.need_clear  = clear;
  assign sts.copy_end    = sweep_r == AW'(COPY_N);
  assign sts.sweep_last  = sweep_r == AW'(CELLS - 1);
  assign sts.out_block   = out_valid_r && !out_tready;

  // memory port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = sweep_r;
    ram_raddr = rd_lin;
    ram_wdata = '0;
    case (cmd.op)
      tct_pkg::OP_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = cur_lin;
        ram_wdata = tct_pkg::make_cell(blink_r, bg_r, fg_r, chr_r);
      end
      tct_pkg::OP_READ: begin
        ram_re = rd_ok;
      end
      tct_pkg::OP_ZERO: begin
        ram_we = 1'b1;
      end
      tct_pkg::OP_BLANK: begin
        ram_we    = 1'b1;
        ram_wdata = tct_pkg::make_cell(blink_r, bg_r, fg_r, tct_pkg::CHR_SPACE);
      end
      tct_pkg::OP_COPY: begin
        // read one row below, write the cell fetched in the previous cycle
        ram_re    = !sts.copy_end;
        ram_raddr = sweep_r + AW'(COLUMNS);
        ram_we    = sweep_r != '0;
        ram_waddr = sweep_r - AW'(1);
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  tct_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  assign read_data = rd_ok ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act_r  <= in_tuser;
      chr_r  <= in_tdata[6:0];
      rrow_r <= in_tdata[12:8];
      rcol_r <= in_tdata[19:13];
    end
    if (cmd.load_out) begin
      out_data_r <= {{PAD_W{1'b0}}, read_data, tct_pkg::POS_FW'(cur_lin),
                     tct_pkg::COL_FW'(col_r), tct_pkg::ROW_FW'(row_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      sweep_r     <= '0;
      blink_r     <= tct_pkg::BLINK_RST;
      bg_r        <= tct_pkg::BG_RST;
      fg_r        <= tct_pkg::FG_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
      if (cmd.sweep_clr) begin
        sweep_r <= '0;
      end else if (cmd.sweep_inc) begin
        sweep_r <= sweep_r + AW'(1);
      end
      if (cfg_we) begin
        case (cfg_idx)
          tct_pkg::REG_BLINK: blink_r <= cfg_wdata[0];
          tct_pkg::REG_BG:    bg_r    <= cfg_wdata[2:0];
          tct_pkg::REG_FG:    fg_r    <= cfg_wdata[3:0];
          default: begin
          end
        endcase
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    case (cfg_idx)
      tct_pkg::REG_BLINK: cfg_rdata = {31'd0, blink_r};
      tct_pkg::REG_BG:    cfg_rdata = {29'd0, bg_r};
      tct_pkg::REG_FG:    cfg_rdata = {28'd0, fg_r};
      default:            cfg_rdata = '0;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ----- src/text_console_terminal.sv -----
// character terminal with a ROWS x COLUMNS screen of 16-bit cells and a cursor
// input stream: tuser is the action (0 = character byte, 1 = read a cell),
//   tdata carries the byte and the cell coordinates; one result item per item
// result stream: cursor row, column and linear position after the item, plus
//   the cell read (zero for character items)
// apb port: blink, background and foreground attributes at 0x0, 0x4, 0x8
// order: one item at a time, set by the controller sequence and the single
//   write port of the screen memory
//   printable, cursor and read items: the item executes, then its result is
//     loaded into the output register
//   scroll (line wrap or newline at the bottom row): each row is copied up one
//     row, then the bottom row is filled with spaces before the result
//   form feed (clear to spaces): every cell is written with a space before the
//     result
// reset: cursor homes, attributes return to their defaults, and a clearing
//   pass writes zero into every cell while in_tready is low
// stall: a finished result waits in the output register while out_tready is
//   low; the next item is still taken and then holds until the register frees
`default_nettype none
module text_console_terminal #(
  parameter int ROWS    = tct_pkg::ROWS_DEF,
  parameter int COLUMNS = tct_pkg::COLUMNS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input items
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // char_code[6:0], zero [7], read_row[12:8], read_col[19:13], zero [23:20]
  input  wire logic [tct_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action[0]
  input  wire logic                            in_tuser,
  // result items
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // cursor_row[4:0], cursor_col[11:5], cursor_position[22:12],
  // read_data[38:23], zero [39]
  output logic      [tct_pkg::OUT_TDATA_W-1:0] out_tdata,
  // configuration
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [tct_pkg::CFG_AW-1:0]      cfg_paddr,
  input  wire logic [tct_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic      [tct_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  tct_pkg::tct_cmd_t cmd;
  tct_pkg::tct_sts_t sts;
  logic              cfg_we;

  // zero-wait apb, register written in the access phase
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // sequencer: reset clear, item decode, scroll and clear sweeps, result hand-off
  tct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // cursor, attributes, sweep counter, screen memory and output register
  tct_datapath #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_paddr[3:2]),
    .cfg_wdata  (cfg_pwdata),
    .cfg_rdata  (cfg_prdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ----- src/tct_checker.sv -----
`default_nettype none
`include "text_console_terminal_assert.svh"
module tct_checker #(
  parameter int ROWS    = tct_pkg::ROWS_DEF,
  parameter int COLUMNS = tct_pkg::COLUMNS_DEF
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [tct_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds
  `TCT_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // reset empties the output register
  `TCT_ASSERT_RST(a_rst_out, !rst_n |=> !out_tvalid, "result valid after reset")

  // only one item in flight
  `TCT_ASSERT(a_one_item, in_tvalid && in_tready |=> !in_tready, "ready stayed high after accept")

  // reported cursor stays on the screen
  `TCT_ASSERT(a_cursor_rng, out_tvalid |-> (32'(out_tdata[4:0]) < ROWS) && (32'(out_tdata[11:5]) < COLUMNS), "cursor off screen")

endmodule

bind text_console_terminal tct_checker #(
  .ROWS    (ROWS),
  .COLUMNS (COLUMNS)
) u_tct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
